// ----- rtl/core/zrlc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero run-length compressor package
// Widths, limits, the result kind code and the word types of both channels.
// ----------------------------------------------------------------------------
package zrlc_pkg;

  localparam int unsigned RUN_CAP      = 65535;
  localparam int unsigned MIN_ZERO_RUN = 8;
  localparam int unsigned HDR_BYTES    = 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned OFF_W   = 32;
  localparam int unsigned FLUSH_W = $clog2(MIN_ZERO_RUN);

  localparam logic [LEN_W-1:0] RunCapLen  = LEN_W'(RUN_CAP);
  localparam logic [LEN_W-1:0] MinZeroLen = LEN_W'(MIN_ZERO_RUN);
  localparam logic [OFF_W-1:0] HdrOff     = OFF_W'(HDR_BYTES);

  typedef enum logic {
    KIND_LITERAL = 1'b0,
    KIND_HEADER  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              is_final;
  } in_word_t;

  typedef struct packed {
    kind_e             kind;
    logic [OFF_W-1:0]  write_offset;
    logic [BYTE_W-1:0] literal_byte;
    logic [LEN_W-1:0]  literal_length;
    logic [LEN_W-1:0]  zero_length;
    logic              stream_done;
  } out_word_t;

endpackage

// ----- rtl/core/zero_run_length_compressor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero run-length compressor
// Turns a byte stream into records [literal length][zero length][literals],
// emitted as offset-addressed literal and header writes.
// ----------------------------------------------------------------------------
// A word that yields at most one write (a literal byte, or a zero that only
// extends the pending run) stalls the input only while the output stalls, so
// words stream in back to back. For a word that closes a record or flushes a
// short zero run, the write engine produces one write per cycle into the output
// register while the output is not stalled, and holds the input while it works.
// Literal writes go out at once past the 4-byte header slot; the header is
// written when its record closes. After a word marked final the offsets
// restart at zero, and the last write of the blob carries stream_done.
module zero_run_length_compressor
  import zrlc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // Architectural state.
  logic [OFF_W-1:0]   off_q, off_d;         // header offset of the open record
  logic [OFF_W-1:0]   lit_off_q, lit_off_d; // offset of the next literal byte
  logic [LEN_W-1:0]   lc_q, lc_d;
  logic [LEN_W-1:0]   pz_q, pz_d;

  // Work still owed for the held word.
  logic               zc_q, zc_d;
  logic [FLUSH_W-1:0] fz_q, fz_d;
  logic               lit_q, lit_d;
  logic               fin_q, fin_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;

  logic               out_valid_q;
  out_word_t          out_q, res;

  logic               cap, fin_close, busy, out_free, fire;
  logic               rem_next, item_done, accept;
  logic [LEN_W-1:0]   pz_inc;

  assign cap       = (lc_q == RunCapLen);
  assign fin_close = fin_q && (lc_q != '0);
  assign busy      = cap || zc_q || (fz_q != '0) || lit_q || fin_close;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fire      = busy && out_free;

  always_comb begin
    off_d     = off_q;
    lit_off_d = lit_off_q;
    lc_d      = lc_q;
    pz_d      = pz_q;
    zc_d      = zc_q;
    fz_d      = fz_q;
    lit_d     = lit_q;
    fin_d     = fin_q;
    byte_d    = byte_q;
    res       = '0;
    pz_inc    = '0;

    // One write per cycle while the output is free, in the order the records require.
    if (fire) begin
      if (cap || zc_q) begin
        res.kind           = KIND_HEADER;
        res.write_offset   = off_q;
        res.literal_length = lc_q;
        res.zero_length    = cap ? '0 : pz_q;
        off_d              = lit_off_q;
        lit_off_d          = lit_off_q + HdrOff;
        lc_d               = '0;
        if (!cap) begin
          pz_d = '0;
          zc_d = 1'b0;
        end
      end else if (fz_q != '0 || lit_q) begin
        res.kind         = KIND_LITERAL;
        res.write_offset = lit_off_q;
        res.literal_byte = (fz_q != '0) ? '0 : byte_q;
        lit_off_d        = lit_off_q + OFF_W'(1);
        lc_d             = lc_q + LEN_W'(1);
        if (fz_q != '0) begin
          fz_d = fz_q - FLUSH_W'(1);
        end else begin
          lit_d = 1'b0;
        end
      end else begin
        res.kind           = KIND_HEADER;
        res.write_offset   = off_q;
        res.literal_length = lc_q;
        off_d              = lit_off_q;
        lit_off_d          = lit_off_q + HdrOff;
        lc_d               = '0;
      end
    end

    rem_next = (lc_d == RunCapLen) || zc_d || (fz_d != '0) || lit_d ||
               (fin_q && (lc_d != '0));
    item_done       = fire && !rem_next;
    res.stream_done = fin_q && !rem_next;

    if (item_done) begin
      fin_d = 1'b0;
      if (fin_q) begin
        off_d     = '0;
        lit_off_d = HdrOff;
        lc_d      = '0;
        pz_d      = '0;
      end
    end

    in_stall_o = busy && !item_done;
    accept     = in_valid_i && !in_stall_o;

    // Decode a new word against the state left by the last write.
    if (accept) begin
      byte_d = in_word_i.data_byte;
      fin_d  = in_word_i.is_final;
      if (in_word_i.data_byte == '0) begin
        pz_inc = pz_d + LEN_W'(1);
        if (pz_inc >= RunCapLen || (in_word_i.is_final && pz_inc >= MinZeroLen)) begin
          zc_d = 1'b1;
          pz_d = pz_inc;
        end else if (in_word_i.is_final) begin
          // A short run at the end of the blob is written out as literals.
          fz_d = pz_inc[FLUSH_W-1:0];
          pz_d = '0;
        end else begin
          pz_d = pz_inc;
        end
      end else begin
        lit_d = 1'b1;
        if (pz_d >= MinZeroLen) begin
          zc_d = 1'b1;
        end else begin
          fz_d = pz_d[FLUSH_W-1:0];
          pz_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      lit_off_q   <= HdrOff;
      lc_q        <= '0;
      pz_q        <= '0;
      zc_q        <= 1'b0;
      fz_q        <= '0;
      lit_q       <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      off_q     <= off_d;
      lit_off_q <= lit_off_d;
      lc_q      <= lc_d;
      pz_q      <= pz_d;
      zc_q      <= zc_d;
      fz_q      <= fz_d;
      lit_q     <= lit_d;
      fin_q     <= fin_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // The blob always ends on a record header.
  a_done_on_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.stream_done |-> out_word_o.kind == KIND_HEADER)
    else $error("stream_done on a literal write");

  // A zero run shorter than the minimum is never a skip.
  a_zero_run_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_HEADER && out_word_o.zero_length != '0
    |-> out_word_o.zero_length >= MinZeroLen)
    else $error("short zero run closed as a skip");

  // No empty record is ever written.
  a_no_empty_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_HEADER
    |-> out_word_o.literal_length != '0 || out_word_o.zero_length != '0)
    else $error("empty record header");

endmodule
